FILE: hdl/slr_pkg.sv
// Package with the constants, codes and shared types of the serial line receiver.
`default_nettype none
package slr_pkg;
	localparam int LINE_BYTES = 64;
	localparam int ADDR_W     = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
	localparam int COUNT_W    = 32;
	localparam int FUNC_W     = 2;
	localparam int BYTE_W     = 8;

	localparam logic [ADDR_W-1:0] LEN_MAX = ADDR_W'(LINE_BYTES - 1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_BYTE    = 2'd0,
		FUNC_OVERRUN = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	localparam logic KIND_LINE  = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic [COUNT_W-1:0] sum;
		logic               eq;
	} inc_res_t;

	typedef struct packed {
		logic [COUNT_W-1:0] a;
		logic [COUNT_W-1:0] b;
	} inc_op_t;
endpackage
`default_nettype wire

FILE: hdl/slr_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface slr_in_if;
	import slr_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [BYTE_W-1:0]   rx_byte;
	modport source(output valid, output func, output rx_byte, input ready);
	modport sink(input valid, input func, input rx_byte, output ready);
endinterface

interface slr_out_if;
	import slr_pkg::*;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [BYTE_W-1:0]   line_byte;
	logic                last;
	logic [COUNT_W-1:0]  error_count;
	modport source(output valid, output kind, output line_byte, output last,
		output error_count, input ready);
	modport sink(input valid, input kind, input line_byte, input last,
		input error_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/slr_line_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slr_line_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: hdl/slr_inc_unit.sv
// Shared incrementer with equality compare, used for counts and indexes.
`default_nettype none
module slr_inc_unit (
	input  wire slr_pkg::inc_op_t  op,
	output slr_pkg::inc_res_t      res
);
	import slr_pkg::*;

	logic [COUNT_W-1:0] sum;

	assign sum     = op.a + COUNT_W'(1);
	assign res.sum = sum;
	assign res.eq  = (sum == op.b);
endmodule
`default_nettype wire

FILE: hdl/serial_line_receiver.sv
// Top level of the serial line receiver: sequencer, line store and shared incrementer.
// A byte, overrun or release item is accepted in idle and carried out in exec. A
// handed-over line sends each byte through read, load and output, plus any output
// stall, and no item is accepted until its last result is taken.
// Throughput is set by the single sequencer around the shared incrementer and RAM port.
// Reset clears line length, corrupt and busy flags and the error count; the store is not.
`default_nettype none
module serial_line_receiver (
	input  wire logic clk,
	input  wire logic arst_n,
	slr_in_if.sink    item,
	slr_out_if.source result
);
	import slr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD,
		S_OUT
	} state_t;

	state_t              state_q;
	func_t               func_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [ADDR_W-1:0]   len_q;
	logic [ADDR_W-1:0]   emit_len_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                corrupt_q;
	logic                busy_q;
	logic [COUNT_W-1:0]  drop_q;
	logic                out_valid_q;
	logic                kind_q;
	logic [BYTE_W-1:0]   obyte_q;
	logic                last_q;

	logic                is_term;
	logic                do_store;
	logic [BYTE_W-1:0]   rd_data;
	inc_op_t             inc_op;
	inc_res_t            inc_res;

	assign is_term  = (byte_q == CH_CR) || (byte_q == CH_LF);
	assign do_store = (state_q == S_EXEC) && (func_q == FUNC_BYTE) && !is_term
		&& (len_q != LEN_MAX);

	always_comb begin
		inc_op.a = drop_q;
		inc_op.b = COUNT_W'(emit_len_q);
		if (state_q == S_LOAD) begin
			inc_op.a = COUNT_W'(idx_q);
		end else if (do_store) begin
			inc_op.a = COUNT_W'(len_q);
		end
	end

	slr_inc_unit u_inc (
		.op  (inc_op),
		.res (inc_res)
	);

	slr_line_ram #(
		.DEPTH  (LINE_BYTES),
		.WIDTH  (BYTE_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_store),
		.wr_addr (len_q),
		.wr_data (byte_q),
		.rd_en   (state_q == S_READ),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign item.ready         = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.kind        = kind_q;
	assign result.line_byte   = obyte_q;
	assign result.last        = last_q;
	assign result.error_count = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			corrupt_q   <= 1'b0;
			busy_q      <= 1'b0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
			func_q      <= FUNC_BYTE;
			byte_q      <= '0;
			emit_len_q  <= '0;
			idx_q       <= '0;
			kind_q      <= KIND_LINE;
			obyte_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						func_q  <= func_t'(item.func);
						byte_q  <= item.rx_byte;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					unique case (func_q)
						FUNC_OVERRUN: begin
							drop_q    <= inc_res.sum;
							corrupt_q <= 1'b1;
						end
						FUNC_RELEASE: begin
							busy_q <= 1'b0;
						end
						FUNC_QUERY: begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_COUNT;
							obyte_q     <= '0;
							last_q      <= 1'b1;
							state_q     <= S_OUT;
						end
						FUNC_BYTE: begin
							if (is_term) begin
								if (len_q != '0) begin
									if (!corrupt_q) begin
										if (!busy_q) begin
											busy_q     <= 1'b1;
											emit_len_q <= len_q;
											idx_q      <= '0;
											state_q    <= S_READ;
										end else begin
											drop_q <= inc_res.sum;
										end
									end
									len_q <= '0;
								end
								corrupt_q <= 1'b0;
							end else if (len_q != LEN_MAX) begin
								len_q <= inc_res.sum[ADDR_W-1:0];
							end else begin
								len_q  <= '0;
								drop_q <= inc_res.sum;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					kind_q      <= KIND_LINE;
					obyte_q     <= rd_data;
					last_q      <= inc_res.eq;
					idx_q       <= inc_res.sum[ADDR_W-1:0];
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
